FILE: rtl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// shared types and constants of the sensor frame parser
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int FrameStoreDepthDef = 20;
  localparam int DecodeBytes        = 20;
  localparam int CountW             = 5;
  localparam int PaddrW             = 5;
  localparam int PdataW             = 32;
  localparam int NumAnalog          = 8;

  localparam logic [3:0] ModeMarker = 4'hF;

  localparam logic [2:0] RegHeaderFirst   = 3'd0;
  localparam logic [2:0] RegHeaderSecond  = 3'd1;
  localparam logic [2:0] RegTrailerFirst  = 3'd2;
  localparam logic [2:0] RegTrailerSecond = 3'd3;
  localparam logic [2:0] RegOffsetMask    = 3'd4;
  localparam logic [2:0] RegDigitalMask   = 3'd5;
  localparam logic [2:0] RegAnalogMask    = 3'd6;

  localparam logic [4:0] LenOffset  = 5'd2;
  localparam logic [4:0] LenDigital = 5'd1;
  localparam logic [4:0] LenAnalog  = 5'd16;

  typedef enum logic [5:0] {
    PhIdle  = 6'b000001,
    PhHead1 = 6'b000010,
    PhHead2 = 6'b000100,
    PhData  = 6'b001000,
    PhTail1 = 6'b010000,
    PhTail2 = 6'b100000
  } sfp_phase_e;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] trailer_first;
    logic [7:0] trailer_second;
    logic [3:0] offset_mask;
    logic [3:0] digital_mask;
    logic [3:0] analog_mask;
  } sfp_cfg_t;

  // frame_mode in the lowest bits, analog_ch7 in the highest
  typedef struct packed {
    logic [NumAnalog-1:0][15:0] analog_ch;
    logic [7:0]                 digital_bits;
    logic [15:0]                offset_value;
    logic [7:0]                 frame_mode;
  } sfp_result_t;

endpackage

FILE: rtl/sfp_regs.sv
// ----------------------------------------------------------------------------
// sfp_regs
// configuration registers behind the apb port
// ----------------------------------------------------------------------------
module sfp_regs
  import sfp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output sfp_cfg_t          cfg_o
);

  sfp_cfg_t   cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[PaddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first   <= 8'hAA;
      cfg_q.header_second  <= 8'h55;
      cfg_q.trailer_first  <= 8'h0D;
      cfg_q.trailer_second <= 8'h0A;
      cfg_q.offset_mask    <= 4'h1;
      cfg_q.digital_mask   <= 4'h2;
      cfg_q.analog_mask    <= 4'h4;
    end else if (wr_en) begin
      case (reg_idx)
        RegHeaderFirst:   cfg_q.header_first   <= pwdata[7:0];
        RegHeaderSecond:  cfg_q.header_second  <= pwdata[7:0];
        RegTrailerFirst:  cfg_q.trailer_first  <= pwdata[7:0];
        RegTrailerSecond: cfg_q.trailer_second <= pwdata[7:0];
        RegOffsetMask:    cfg_q.offset_mask    <= pwdata[3:0];
        RegDigitalMask:   cfg_q.digital_mask   <= pwdata[3:0];
        RegAnalogMask:    cfg_q.analog_mask    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegHeaderFirst:   prdata = {24'd0, cfg_q.header_first};
      RegHeaderSecond:  prdata = {24'd0, cfg_q.header_second};
      RegTrailerFirst:  prdata = {24'd0, cfg_q.trailer_first};
      RegTrailerSecond: prdata = {24'd0, cfg_q.trailer_second};
      RegOffsetMask:    prdata = {28'd0, cfg_q.offset_mask};
      RegDigitalMask:   prdata = {28'd0, cfg_q.digital_mask};
      RegAnalogMask:    prdata = {28'd0, cfg_q.analog_mask};
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/sfp_parser.sv
// ----------------------------------------------------------------------------
// sfp_parser
// byte-level frame state machine and payload store
// ----------------------------------------------------------------------------
module sfp_parser
  import sfp_pkg::*;
#(
  parameter int FrameStoreDepth = FrameStoreDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sfp_cfg_t   cfg_i,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  output logic       emit_o,
  output logic [7:0] store_o [DecodeBytes]
);

  localparam int IdxW = $clog2(FrameStoreDepth);
  localparam logic [CountW:0] DepthLim = (CountW+1)'(FrameStoreDepth);

  sfp_phase_e        phase_q, phase_d;
  logic [CountW-1:0] wpos_q, wpos_d;
  logic [CountW-1:0] expect_q, expect_d;
  logic [CountW-1:0] seen_q, seen_d;
  logic [CountW-1:0] seen_inc;
  logic [CountW-1:0] pay_len;
  logic [7:0]        store_q [FrameStoreDepth];
  logic              st_we;
  logic [IdxW-1:0]   st_wa;
  logic              emit;

  always_comb begin
    pay_len = '0;
    if (|(byte_i[3:0] & cfg_i.offset_mask))  pay_len = pay_len + LenOffset;
    if (|(byte_i[3:0] & cfg_i.digital_mask)) pay_len = pay_len + LenDigital;
    if (|(byte_i[3:0] & cfg_i.analog_mask))  pay_len = pay_len + LenAnalog;
  end

  assign seen_inc = seen_q + CountW'(1);

  always_comb begin
    phase_d  = phase_q;
    wpos_d   = wpos_q;
    expect_d = expect_q;
    seen_d   = seen_q;
    st_we    = 1'b0;
    st_wa    = '0;
    emit     = 1'b0;
    if (byte_valid_i) begin
      case (phase_q)
        PhIdle: begin
          if (byte_i == cfg_i.header_first) phase_d = PhHead1;
        end
        PhHead1: begin
          wpos_d = '0;
          if (byte_i == cfg_i.header_second) begin
            phase_d = PhHead2;
          end else begin
            phase_d  = PhIdle;
            expect_d = '0;
            seen_d   = '0;
          end
        end
        PhHead2: begin
          st_we = 1'b1;
          if (byte_i[7:4] == ModeMarker) begin
            wpos_d   = CountW'(1);
            expect_d = pay_len;
            seen_d   = '0;
            phase_d  = (pay_len == '0) ? PhTail1 : PhData;
          end else begin
            phase_d  = PhIdle;
            wpos_d   = '0;
            expect_d = '0;
            seen_d   = '0;
          end
        end
        PhData: begin
          if ({1'b0, wpos_q} < DepthLim) begin
            st_we  = 1'b1;
            st_wa  = wpos_q[IdxW-1:0];
            wpos_d = wpos_q + CountW'(1);
          end
          seen_d = seen_inc;
          if (seen_inc >= expect_q) phase_d = PhTail1;
        end
        PhTail1: begin
          if (byte_i == cfg_i.trailer_first) begin
            phase_d = PhTail2;
          end else begin
            phase_d  = PhIdle;
            wpos_d   = '0;
            expect_d = '0;
            seen_d   = '0;
          end
        end
        PhTail2: begin
          emit     = (byte_i == cfg_i.trailer_second);
          phase_d  = PhIdle;
          wpos_d   = '0;
          expect_d = '0;
          seen_d   = '0;
        end
        default: begin
          phase_d  = PhIdle;
          wpos_d   = '0;
          expect_d = '0;
          seen_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      wpos_q   <= '0;
      expect_q <= '0;
      seen_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      wpos_q   <= wpos_d;
      expect_q <= expect_d;
      seen_q   <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) store_q[st_wa] <= byte_i;
  end

  for (genvar i = 0; i < DecodeBytes; i++) begin : g_tap
    assign store_o[i] = store_q[i];
  end

  assign emit_o = emit;

endmodule

FILE: rtl/sfp_decode.sv
// ----------------------------------------------------------------------------
// sfp_decode
// unpacks the stored frame into the result fields
// ----------------------------------------------------------------------------
module sfp_decode
  import sfp_pkg::*;
(
  input  sfp_cfg_t    cfg_i,
  input  logic [7:0]  store_i [DecodeBytes],
  output sfp_result_t result_o
);

  logic       has_off;
  logic       has_dig;
  logic       has_ana;
  logic [1:0] ana_sel;

  assign has_off = |(store_i[0][3:0] & cfg_i.offset_mask);
  assign has_dig = |(store_i[0][3:0] & cfg_i.digital_mask);
  assign has_ana = |(store_i[0][3:0] & cfg_i.analog_mask);
  // analog words start right after the offset and digital parts
  assign ana_sel = {has_off, has_dig};

  always_comb begin
    result_o              = '0;
    result_o.frame_mode   = store_i[0];
    if (has_off) result_o.offset_value = {store_i[2], store_i[1]};
    if (has_dig) result_o.digital_bits = has_off ? store_i[3] : store_i[1];
    if (has_ana) begin
      for (int i = 0; i < NumAnalog; i++) begin
        case (ana_sel)
          2'b00:   result_o.analog_ch[i] = {store_i[2*i+2], store_i[2*i+1]};
          2'b01:   result_o.analog_ch[i] = {store_i[2*i+3], store_i[2*i+2]};
          2'b10:   result_o.analog_ch[i] = {store_i[2*i+4], store_i[2*i+3]};
          default: result_o.analog_ch[i] = {store_i[2*i+5], store_i[2*i+4]};
        endcase
      end
    end
  end

endmodule

FILE: rtl/sensor_frame_parser.sv
// ----------------------------------------------------------------------------
// sensor_frame_parser
// byte-serial sensor frame parser with apb configuration
// ----------------------------------------------------------------------------
// One received byte per input item, one byte per clock when the result side
// keeps up. Each byte advances the frame state machine in the cycle it is
// accepted; on the second tail byte the stored frame is unpacked and loaded
// into the result register, so the result item is offered the cycle after
// that byte. Input stalls only while a finished result sits in the result
// register and is not taken. Header, tail and flag mask values come from the
// apb registers and should only be changed between frames.
module sensor_frame_parser
  import sfp_pkg::*;
#(
  parameter int FrameStoreDepth = FrameStoreDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // rx_byte
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // frame_mode, offset_value, digital_bits, analog_ch0 .. analog_ch7
  output logic [159:0]      m_axis_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  sfp_cfg_t    cfg;
  logic        in_acc;
  logic        emit;
  logic [7:0]  store [DecodeBytes];
  sfp_result_t result;
  sfp_result_t result_q;
  logic        mvalid_q;

  sfp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign s_axis_tready = !mvalid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  sfp_parser #(
    .FrameStoreDepth (FrameStoreDepth)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .byte_valid_i (in_acc),
    .byte_i       (s_axis_tdata),
    .emit_o       (emit),
    .store_o      (store)
  );

  sfp_decode u_decode (
    .cfg_i    (cfg),
    .store_i  (store),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvalid_q <= 1'b0;
    end else if (emit) begin
      mvalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      mvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) result_q <= result;
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = result_q;

  a_emit_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> in_acc)
    else $error("result produced without an accepted item");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!mvalid_q || m_axis_tready))
    else $error("pending result overwritten");

  a_mode_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (m_axis_tvalid && m_axis_tdata[7:4] == ModeMarker))
    else $error("result mode byte lacks marker nibble");

endmodule

FILE: tb/tb_sensor_frame_parser.sv
// ----------------------------------------------------------------------------
// tb_sensor_frame_parser
// self-checking bench for the byte-serial sensor frame parser
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes comes first: empty and offset frames, a
// repeated first header byte and a bad mode byte. Random frames follow under
// six register settings: the reset values, extreme header and tail values,
// all masks set, all masks clear, overlapping masks and a random set. Most of
// these frames are well formed. The rest have a bad mode, a corrupted byte or
// a missing end, and random bytes fall between frames. A model of the parser
// inside the bench predicts every decoded frame. Each frame that comes out is
// compared with the prediction field by field. Both stream sides pause at
// random, and once the output side holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_sensor_frame_parser;
  import sfp_pkg::*;

  localparam logic [2:0] RegSpare      = 3'd7;
  localparam int         WatchdogLimit = 3000;
  localparam int         PhaseBytes    = 255;
  localparam int         RxHoldCycles  = 300;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        typed;
    sfp_result_t frame;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;   // rx_byte
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // frame_mode, offset_value, digital_bits, analog_ch0 .. analog_ch7
  logic [159:0]      m_axis_tdata;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [PaddrW-1:0] paddr         = '0;
  logic [PdataW-1:0] pwdata        = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;

  sfp_cfg_t    cfg;
  sfp_phase_e  parse_state;
  logic [4:0]  wr_pos;
  logic [4:0]  len_due;
  logic [4:0]  len_seen;
  logic [7:0]  frame_bytes [FrameStoreDepthDef];

  sfp_result_t frames_due [$];
  int          rx_sent        = 0;
  int          frames_checked = 0;
  int          mismatches     = 0;
  bit          tx_burst       = 1'b0;
  bit          rx_burst       = 1'b0;
  bit          rx_hold_req    = 1'b0;

  sensor_frame_parser DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic stim_row_t stim_row(input logic [7:0] rx, input logic typed = 1'b0,
                                         input sfp_result_t fr = '0);
    stim_row_t r;
    r.rx_byte = rx;
    r.typed   = typed;
    r.frame   = fr;
    return r;
  endfunction

  function automatic void clear_parse();
    parse_state = PhIdle;
    wr_pos      = '0;
    len_due     = '0;
    len_seen    = '0;
  endfunction

  // advance the parser model by one byte, returning a frame when one completes
  task automatic parse_rx_byte(input logic [7:0] rx, output logic done,
                               output sfp_result_t fr);
    logic [7:0] mode;
    int         pos;
    done = 1'b0;
    fr   = '0;
    case (parse_state)
      PhIdle: begin
        if (rx == cfg.header_first) parse_state = PhHead1;
      end
      PhHead1: begin
        if (rx == cfg.header_second) begin
          parse_state = PhHead2;
          wr_pos      = '0;
        end else begin
          clear_parse();
        end
      end
      PhHead2: begin
        frame_bytes[0] = rx;
        wr_pos         = 5'd1;
        if (rx[7:4] == ModeMarker) begin
          len_due = '0;
          if ((rx[3:0] & cfg.offset_mask) != 4'h0) len_due += LenOffset;
          if ((rx[3:0] & cfg.digital_mask) != 4'h0) len_due += LenDigital;
          if ((rx[3:0] & cfg.analog_mask) != 4'h0) len_due += LenAnalog;
          len_seen    = '0;
          parse_state = (len_due == '0) ? PhTail1 : PhData;
        end else begin
          clear_parse();
        end
      end
      PhData: begin
        if (wr_pos < FrameStoreDepthDef) begin
          frame_bytes[wr_pos] = rx;
          wr_pos++;
        end
        len_seen++;
        if (len_seen >= len_due) parse_state = PhTail1;
      end
      PhTail1: begin
        if (rx == cfg.trailer_first) parse_state = PhTail2;
        else clear_parse();
      end
      PhTail2: begin
        if (rx == cfg.trailer_second) begin
          mode          = frame_bytes[0];
          pos           = 1;
          fr.frame_mode = mode;
          if ((mode[3:0] & cfg.offset_mask) != 4'h0) begin
            fr.offset_value = {frame_bytes[pos+1], frame_bytes[pos]};
            pos += 2;
          end
          if ((mode[3:0] & cfg.digital_mask) != 4'h0) begin
            fr.digital_bits = frame_bytes[pos];
            pos += 1;
          end
          if ((mode[3:0] & cfg.analog_mask) != 4'h0) begin
            for (int i = 0; i < NumAnalog; i++) begin
              fr.analog_ch[i] = {frame_bytes[pos+1], frame_bytes[pos]};
              pos += 2;
            end
          end
          done = 1'b1;
        end
        clear_parse();
      end
      default: clear_parse();
    endcase
  endtask

  task automatic send_rx(input logic [7:0] rx, input logic typed = 1'b0,
                         input sfp_result_t typed_fr = '0);
    int          gap;
    logic        done;
    sfp_result_t fr;
    gap = pick_gap(tx_burst);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    rx_sent++;
    parse_rx_byte(rx, done, fr);
    if (typed) frames_due.push_back(typed_fr);
    else if (done) frames_due.push_back(fr);
  endtask

  // mostly well-formed frames, some broken, some noise in between
  task automatic send_random_frame();
    logic [7:0] bytes_q [$];
    logic [7:0] mode;
    int         pick;
    int         len;
    int         n_send;
    if ($urandom_range(0, 15) == 0) tx_burst = ~tx_burst;
    pick = $urandom_range(0, 99);
    mode = {ModeMarker, 4'($urandom_range(0, 15))};
    if (pick < 8) mode = 8'($urandom_range(0, 255));
    len = 0;
    if ((mode[3:0] & cfg.offset_mask) != 4'h0) len += LenOffset;
    if ((mode[3:0] & cfg.digital_mask) != 4'h0) len += LenDigital;
    if ((mode[3:0] & cfg.analog_mask) != 4'h0) len += LenAnalog;
    bytes_q = '{cfg.header_first, cfg.header_second, mode};
    repeat (len) bytes_q.push_back(8'($urandom_range(0, 255)));
    bytes_q.push_back(cfg.trailer_first);
    bytes_q.push_back(cfg.trailer_second);
    if (pick >= 8 && pick < 16)
      bytes_q[$urandom_range(0, bytes_q.size() - 1)] = 8'($urandom_range(0, 255));
    n_send = (pick >= 16 && pick < 20) ? $urandom_range(1, bytes_q.size() - 1)
                                       : bytes_q.size();
    for (int i = 0; i < n_send; i++) send_rx(bytes_q[i]);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_rx(8'($urandom_range(0, 255)));
  endtask

  // bring the parser back to idle and drain all frames before a register write
  task automatic settle();
    logic [7:0] fill;
    while (parse_state != PhIdle) begin
      case (parse_state)
        PhHead1: fill = cfg.header_second ^ 8'h01;
        PhHead2: fill = 8'h00;
        PhTail1: fill = cfg.trailer_first ^ 8'h01;
        PhTail2: fill = cfg.trailer_second ^ 8'h01;
        default: fill = 8'($urandom_range(0, 255));
      endcase
      send_rx(fill);
    end
    s_axis_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write with random upper bits, then read back the masked value
  task automatic set_reg(input logic [2:0] idx, input logic [7:0] field);
    logic [PdataW-1:0] wdata;
    logic [PdataW-1:0] rd_want;
    logic              rd_known;
    wdata    = $urandom;
    rd_known = 1'b1;
    case (idx)
      RegHeaderFirst: begin
        wdata[7:0] = field; cfg.header_first = field; rd_want = {24'b0, field};
      end
      RegHeaderSecond: begin
        wdata[7:0] = field; cfg.header_second = field; rd_want = {24'b0, field};
      end
      RegTrailerFirst: begin
        wdata[7:0] = field; cfg.trailer_first = field; rd_want = {24'b0, field};
      end
      RegTrailerSecond: begin
        wdata[7:0] = field; cfg.trailer_second = field; rd_want = {24'b0, field};
      end
      RegOffsetMask: begin
        wdata[3:0] = field[3:0]; cfg.offset_mask = field[3:0]; rd_want = {28'b0, field[3:0]};
      end
      RegDigitalMask: begin
        wdata[3:0] = field[3:0]; cfg.digital_mask = field[3:0]; rd_want = {28'b0, field[3:0]};
      end
      RegAnalogMask: begin
        wdata[3:0] = field[3:0]; cfg.analog_mask = field[3:0]; rd_want = {28'b0, field[3:0]};
      end
      default: begin
        rd_known = 1'b0;
        rd_want  = '0;
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd_known && prdata !== rd_want) begin
      mismatches++;
      $display("%0t: register %0d read expected %h got %h", $time, idx, rd_want, prdata);
    end
    @(posedge clk_i);
  endtask

  task automatic program_cfg(input logic [7:0] hf, input logic [7:0] hs,
                             input logic [7:0] tf, input logic [7:0] ts,
                             input logic [3:0] om, input logic [3:0] dm,
                             input logic [3:0] am);
    set_reg(RegHeaderFirst, hf);
    set_reg(RegHeaderSecond, hs);
    set_reg(RegTrailerFirst, tf);
    set_reg(RegTrailerSecond, ts);
    set_reg(RegOffsetMask, {4'h0, om});
    set_reg(RegDigitalMask, {4'h0, dm});
    set_reg(RegAnalogMask, {4'h0, am});
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  task automatic check_frame(input sfp_result_t got);
    sfp_result_t want;
    if (frames_due.size() == 0) begin
      mismatches++;
      $display("%0t: frame with none expected, got %h", $time, got);
    end else begin
      want = frames_due.pop_front();
      frames_checked++;
      check_field("frame_mode", want.frame_mode, got.frame_mode);
      check_field("offset_value", want.offset_value, got.offset_value);
      check_field("digital_bits", want.digital_bits, got.digital_bits);
      for (int i = 0; i < NumAnalog; i++)
        check_field($sformatf("analog_ch%0d", i), want.analog_ch[i], got.analog_ch[i]);
    end
  endtask

  initial begin : frame_sink
    int gap;
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
      gap = pick_gap(rx_burst);
      if (rx_hold_req) begin
        gap         = RxHoldCycles;
        rx_hold_req = 1'b0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      check_frame(sfp_result_t'(m_axis_tdata));
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item moved for %0d cycles", $time, WatchdogLimit);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    sfp_result_t empty_fr;
    sfp_result_t offset_fr;
    stim_row_t   directed_rows [23];
    int          phase_start;

    cfg = '{8'hAA, 8'h55, 8'h0D, 8'h0A, 4'h1, 4'h2, 4'h4};
    clear_parse();
    foreach (frame_bytes[i]) frame_bytes[i] = '0;

    empty_fr                = '0;
    empty_fr.frame_mode     = 8'hF0;
    offset_fr               = '0;
    offset_fr.frame_mode    = 8'hF1;
    offset_fr.offset_value  = 16'hFF00;

    directed_rows = '{
      // empty payload
      stim_row(8'hAA), stim_row(8'h55), stim_row(8'hF0), stim_row(8'h0D),
      stim_row(8'h0A, 1'b1, empty_fr),
      // offset only, byte extremes
      stim_row(8'hAA), stim_row(8'h55), stim_row(8'hF1), stim_row(8'h00),
      stim_row(8'hFF), stim_row(8'h0D), stim_row(8'h0A, 1'b1, offset_fr),
      // repeated first header byte is not taken as a new start
      stim_row(8'hAA), stim_row(8'hAA), stim_row(8'h55), stim_row(8'hF2),
      stim_row(8'h0D), stim_row(8'h0A),
      // mode byte without the marker nibble
      stim_row(8'hAA), stim_row(8'h55), stim_row(8'h0F), stim_row(8'h0D),
      stim_row(8'h0A)
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_rx(directed_rows[i].rx_byte, directed_rows[i].typed, directed_rows[i].frame);

    rx_hold_req = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        settle();
        case (ph)
          1: begin
            program_cfg(8'hFF, 8'h00, 8'h00, 8'hFF, 4'h8, 4'h4, 4'h1);
            set_reg(RegSpare, 8'($urandom_range(0, 255)));
          end
          2: program_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         4'hF, 4'hF, 4'hF);
          3: program_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         4'h0, 4'h0, 4'h0);
          4: program_cfg(8'hAA, 8'h55, 8'h0D, 8'h0A, 4'h3, 4'h6, 4'hC);
          default: program_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                               4'($urandom_range(0, 15)));
        endcase
      end
      phase_start = rx_sent;
      while (rx_sent - phase_start < PhaseBytes) send_random_frame();
    end

    s_axis_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d bytes sent under six register settings, %0d decoded frames compared",
             rx_sent, frames_checked);
    $display("payload layouts from empty to nineteen bytes, broken frames and a held-off sink");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
